/* sv/stlfc_pkg.sv */
// ============================================================================
// ASCII STL facet counter: shared package
// Types, character constants and keyword tables used by the front end, the
// scanner back end and the top level.
// ============================================================================
`default_nettype none

package stlfc_pkg;

    // Default counter widths for the top-level parameters.
    localparam int COUNT_BITS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 32;

    // Entries in each of the two queues.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_COUNT_FACETS = 1'b0;
    localparam logic CFG_MEASURE_SIZE = 1'b1;

    // Characters the scanner looks for.
    localparam logic [7:0] CHAR_F  = 8'h66;
    localparam logic [7:0] CHAR_E  = 8'h65;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Keyword lengths: "facet" and "endsolid".
    localparam logic [3:0] LEN_FACET = 4'd5;
    localparam logic [3:0] LEN_END   = 4'd8;

    // One classified byte, as handed from the front end to the scanner.
    typedef struct packed {
        logic [7:0] low_byte;
        logic       is_space;
        logic       is_newline;
        logic       last;
    } cls_t;

    // One result, as held in the result queue.
    typedef struct packed {
        logic [31:0] facet_total;
        logic [31:0] solid_bytes;
        logic        end_cause;
    } result_t;

    // Character expected at a given position of the selected keyword.
    // Select 0 is "facet", select 1 is "endsolid".
    function automatic logic [7:0] keyword_char(input logic sel, input logic [2:0] pos);
        logic [7:0] ch;
        if (sel) begin
            case (pos)
                3'd0:    ch = 8'h65; // e
                3'd1:    ch = 8'h6E; // n
                3'd2:    ch = 8'h64; // d
                3'd3:    ch = 8'h73; // s
                3'd4:    ch = 8'h6F; // o
                3'd5:    ch = 8'h6C; // l
                3'd6:    ch = 8'h69; // i
                default: ch = 8'h64; // d
            endcase
        end
        else begin
            case (pos)
                3'd0:    ch = 8'h66; // f
                3'd1:    ch = 8'h61; // a
                3'd2:    ch = 8'h63; // c
                3'd3:    ch = 8'h65; // e
                default: ch = 8'h74; // t
            endcase
        end
        return ch;
    endfunction

    // Clamp a counter value to the 32-bit result field.
    function automatic logic [31:0] sat32(input logic [63:0] value);
        logic [31:0] res;
        if (|value[63:32]) begin
            res = 32'hFFFF_FFFF;
        end
        else begin
            res = value[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/stlfc_fifo.sv */
// ============================================================================
// ASCII STL facet counter: small queue
// A first-in first-out store of a few entries with full and empty flags.
// ============================================================================
`default_nettype none

module stlfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // Pointer and fill-level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* sv/stlfc_front.sv */
// ============================================================================
// ASCII STL facet counter: front end
// Takes in text bytes and classifies each one: whitespace, line break and
// the byte folded to lower case.
// ============================================================================
`default_nettype none

module stlfc_front (
    input  wire logic             push,
    input  wire logic [7:0]       text_byte,
    input  wire logic             stream_last,
    input  wire logic             queue_full,
    output logic                  cls_write,
    output stlfc_pkg::cls_t       cls
);

    // A request is taken whenever the classified-byte queue has room.
    assign cls_write = push && !queue_full;

    // Classification of the incoming byte.
    always_comb
    begin
        cls.is_space   = (text_byte inside {[8'h09:8'h0D], 8'h20});
        cls.is_newline = (text_byte == stlfc_pkg::CHAR_LF) ||
                         (text_byte == stlfc_pkg::CHAR_CR);
        cls.low_byte   = (text_byte inside {[8'h41:8'h5A]}) ? (text_byte | 8'h20)
                                                           : text_byte;
        cls.last       = stream_last;
    end

endmodule

`default_nettype wire

/* sv/stlfc_back.sv */
// ============================================================================
// ASCII STL facet counter: scanner back end
// Runs the token state machine on classified bytes, keeps the facet and
// byte counters and writes one result per stream into the result queue.
// ============================================================================
`default_nettype none

module stlfc_back #(
    parameter int COUNT_BITS = stlfc_pkg::COUNT_BITS_DEF,
    parameter int SIZE_BITS  = stlfc_pkg::SIZE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 count_facets,
    input  wire logic                 measure_size,
    input  wire logic                 cls_avail,
    input  wire stlfc_pkg::cls_t      cls,
    output logic                      cls_take,
    input  wire logic                 res_full,
    output logic                      res_write,
    output stlfc_pkg::result_t        res
);

    // Scan phases.
    localparam logic [2:0] PH_GAP   = 3'd0;
    localparam logic [2:0] PH_MATCH = 3'd1;
    localparam logic [2:0] PH_TOKEN = 3'd2;
    localparam logic [2:0] PH_LINE  = 3'd3;
    localparam logic [2:0] PH_TRAIL = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic                  sel_reg;
    logic                  sel_next;
    logic [2:0]            pos_reg;
    logic [2:0]            pos_next;
    logic [COUNT_BITS-1:0] facet_reg;
    logic [COUNT_BITS-1:0] facet_next;
    logic [SIZE_BITS-1:0]  bytes_reg;
    logic [SIZE_BITS-1:0]  bytes_next;
    logic [3:0]            kw_len;
    logic [7:0]            kw_want;

    // A byte is handled only when a result could be stored for it.
    assign cls_take = cls_avail && !res_full;

    assign kw_len  = sel_reg ? stlfc_pkg::LEN_END : stlfc_pkg::LEN_FACET;
    assign kw_want = stlfc_pkg::keyword_char(sel_reg, pos_reg);

    // Token state machine and counters.
    always_comb
    begin
        phase_next        = phase_reg;
        sel_next          = sel_reg;
        pos_next          = pos_reg;
        facet_next        = facet_reg;
        bytes_next        = bytes_reg;
        res_write         = 1'b0;
        res.end_cause     = 1'b0;
        res.facet_total   = '0;
        res.solid_bytes   = '0;
        if (cls_take) begin
            if (phase_reg == PH_TRAIL && !cls.is_space) begin
                // First non-space byte after the closing line ends the solid.
                res_write  = 1'b1;
                phase_next = PH_DONE;
            end
            else if (phase_reg != PH_DONE) begin
                if (bytes_reg != {SIZE_BITS{1'b1}}) begin
                    bytes_next = bytes_reg + 1'b1;
                end
                case (phase_reg)
                    PH_GAP:
                    begin
                        if (!cls.is_space) begin
                            if (cls.low_byte == stlfc_pkg::CHAR_F ||
                                cls.low_byte == stlfc_pkg::CHAR_E) begin
                                sel_next   = (cls.low_byte == stlfc_pkg::CHAR_E);
                                pos_next   = 3'd1;
                                phase_next = PH_MATCH;
                            end
                            else begin
                                phase_next = PH_TOKEN;
                            end
                        end
                    end
                    PH_MATCH:
                    begin
                        if ({1'b0, pos_reg} >= kw_len || cls.low_byte != kw_want) begin
                            phase_next = cls.is_space ? PH_GAP : PH_TOKEN;
                        end
                        else if ({1'b0, pos_reg} + 4'd1 < kw_len) begin
                            pos_next = pos_reg + 3'd1;
                        end
                        else if (!sel_reg) begin
                            if (count_facets && facet_reg != {COUNT_BITS{1'b1}}) begin
                                facet_next = facet_reg + 1'b1;
                            end
                            phase_next = PH_TOKEN;
                        end
                        else if (measure_size) begin
                            phase_next = PH_LINE;
                        end
                        else begin
                            res_write  = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (cls.is_space) begin
                            phase_next = PH_GAP;
                        end
                    end
                    PH_LINE:
                    begin
                        if (cls.is_newline) begin
                            phase_next = PH_TRAIL;
                        end
                    end
                    PH_TRAIL:
                    begin
                        phase_next = PH_TRAIL;
                    end
                    default:
                    begin
                        phase_next = PH_GAP;
                    end
                endcase
            end

            // Result fields follow the counters after this byte.
            res.facet_total = count_facets ? stlfc_pkg::sat32(64'(facet_next)) : '0;
            res.solid_bytes = measure_size ? stlfc_pkg::sat32(64'(bytes_next)) : '0;

            // End of stream: answer if nothing was given yet, then restart.
            if (cls.last) begin
                if (!res_write && phase_next != PH_DONE) begin
                    res_write     = 1'b1;
                    res.end_cause = !(phase_next == PH_LINE || phase_next == PH_TRAIL);
                end
                phase_next = PH_GAP;
                sel_next   = 1'b0;
                pos_next   = '0;
                facet_next = '0;
                bytes_next = '0;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_GAP;
            sel_reg   <= 1'b0;
            pos_reg   <= '0;
            facet_reg <= '0;
            bytes_reg <= '0;
        end
        else begin
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
            pos_reg   <= pos_next;
            facet_reg <= facet_next;
            bytes_reg <= bytes_next;
        end
    end

`ifndef SYNTHESIS
    // A result is only ever produced while a byte is being handled.
    assert property (@(posedge clk) disable iff (!rst_n) res_write |-> cls_take)
        else $error("result written without a byte being handled");

    // Once a stream has been answered, nothing more is written for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> !res_write)
        else $error("second result for one stream");

    // The end of a stream leaves the scanner cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cls_take && cls.last) |=>
        (phase_reg == PH_GAP && facet_reg == '0 && bytes_reg == '0))
        else $error("scanner not cleared after end of stream");

    // Counters only grow within a stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cls_take && cls.last) |=>
        (facet_reg >= $past(facet_reg) && bytes_reg >= $past(bytes_reg)))
        else $error("counter went backwards within a stream");
`endif

endmodule

`default_nettype wire

/* sv/ascii_stl_facet_counter.sv */
// ============================================================================
// ASCII STL facet counter: top level
// Scans ASCII STL text one byte at a time, counts facet tokens up to
// endsolid and measures the length of the first solid.
// ============================================================================
//
//  Channel  | Handshake        | Payload
//  ---------+------------------+----------------------------------------
//  input    | push / full      | text_byte, stream_last
//  result   | pop / empty      | facet_total, solid_bytes, end_cause
//  config   | cfg_write        | cfg_index, cfg_data
//
//  One byte is taken per cycle while full is low; the scanner handles one byte
//  a cycle while the result queue has room. A result is registered in the
//  result queue before it shows on the result ports. Reset clears the scanner,
//  both queues and sets both configuration registers to 1; there is no
//  clearing pass. When pop stays low the two-entry result queue fills, the
//  scanner stops and full rises once the two-entry byte queue is full as well.
//
`default_nettype none

module ascii_stl_facet_counter #(
    parameter int COUNT_BITS = stlfc_pkg::COUNT_BITS_DEF,
    parameter int SIZE_BITS  = stlfc_pkg::SIZE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  text_byte,
    input  wire logic        stream_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      facet_total,
    output logic [31:0]      solid_bytes,
    output logic             end_cause,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    localparam int CLS_W = $bits(stlfc_pkg::cls_t);
    localparam int RES_W = $bits(stlfc_pkg::result_t);

    logic                 count_facets_reg;
    logic                 count_facets_next;
    logic                 measure_size_reg;
    logic                 measure_size_next;
    logic                 cls_write;
    stlfc_pkg::cls_t      cls_in;
    stlfc_pkg::cls_t      cls_out;
    logic                 cls_empty;
    logic                 cls_take;
    logic                 res_full;
    logic                 res_write;
    stlfc_pkg::result_t   res_in;
    stlfc_pkg::result_t   res_out;

    // Configuration registers.
    always_comb
    begin
        count_facets_next = count_facets_reg;
        measure_size_next = measure_size_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                stlfc_pkg::CFG_COUNT_FACETS: count_facets_next = cfg_data;
                stlfc_pkg::CFG_MEASURE_SIZE: measure_size_next = cfg_data;
                default:                     count_facets_next = count_facets_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_facets_reg <= 1'b1;
            measure_size_reg <= 1'b1;
        end
        else
        begin
            count_facets_reg <= count_facets_next;
            measure_size_reg <= measure_size_next;
        end
    end

    // Byte classification.
    stlfc_front u_front (
        .push        (push),
        .text_byte   (text_byte),
        .stream_last (stream_last),
        .queue_full  (full),
        .cls_write   (cls_write),
        .cls         (cls_in)
    );

    // Queue of classified bytes between front and back.
    stlfc_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (stlfc_pkg::QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cls_write),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (cls_take),
        .rd_data (cls_out),
        .empty   (cls_empty)
    );

    // Token scanner.
    stlfc_back #(
        .COUNT_BITS (COUNT_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .count_facets (count_facets_reg),
        .measure_size (measure_size_reg),
        .cls_avail    (!cls_empty),
        .cls          (cls_out),
        .cls_take     (cls_take),
        .res_full     (res_full),
        .res_write    (res_write),
        .res          (res_in)
    );

    // Result queue towards the consumer.
    stlfc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (stlfc_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_write),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign facet_total = res_out.facet_total;
    assign solid_bytes = res_out.solid_bytes;
    assign end_cause   = res_out.end_cause;

endmodule

`default_nettype wire
